@@ hw/rtl/fkd_pkg.sv @@
// Shared types, constants and keyword-match function for the framed receive keyword detector.
package fkd_pkg;

   localparam int BUF_LEN    = 256;
   localparam int CNT_W      = $clog2(BUF_LEN);
   localparam int BANK_DEPTH = BUF_LEN / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam logic [1:0] KIND_BYTE       = 2'd0;
   localparam logic [1:0] KIND_RELEASE    = 2'd1;
   localparam logic [1:0] KIND_CLEAR_LOST = 2'd2;
   localparam logic [1:0] KIND_READ       = 2'd3;

   localparam logic [7:0] CH_MARK = 8'h40;
   localparam logic [7:0] CH_END  = 8'h2A;
   localparam logic [7:0] CH_NUL  = 8'h00;

   // Patterns packed with the first character in the lowest byte.
   localparam logic [15:0][7:0] CLOSED_PAT = {80'd0, "DESOLC"};
   localparam logic [3:0]       CLOSED_LEN = 4'd6;
   localparam logic [15:0][7:0] DISC_PAT   = {8'd0, "TCENNOCSID IFIW"};
   localparam logic [3:0]       DISC_LEN   = 4'd15;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } item_type;

   typedef struct packed {
      logic             done;
      logic             armed;
      logic [CNT_W-1:0] count;
      logic             lost;
      logic             dropped;
   } status_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] pos;
      logic [7:0]       data;
   } wr_type;

   typedef struct packed {
      logic [3:0] pos;
      logic       hit;
   } kw_step_type;

   // One step of a restart matcher: advance on a hit, restart on a miss.
   function automatic kw_step_type kw_step(input logic [15:0][7:0] pat, input logic [3:0] len,
                                           input logic [3:0] pos, input logic [7:0] b);
      kw_step_type r;
      logic [3:0]  p;
      p = (pos >= len) ? 4'd0 : pos;
      r.hit = 1'b0;
      if (b == pat[p]) begin
         if (p + 4'd1 >= len) begin
            r.hit = 1'b1;
            r.pos = 4'd0;
         end else begin
            r.pos = p + 4'd1;
         end
      end else begin
         r.pos = (b == pat[0]) ? 4'd1 : 4'd0;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/fkd_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fkd_core.sv @@
// Frame state, keyword matchers and link-lost flag; issues buffer writes.
module fkd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  fkd_pkg::item_type   item,
   output fkd_pkg::status_type status,
   output fkd_pkg::wr_type     wr
);

   logic                     done_ff, done_in;
   logic                     armed_ff, armed_in;
   logic [fkd_pkg::CNT_W-1:0] count_ff, count_in;
   logic                     lost_ff, lost_in;
   logic [2:0]               closed_pos_ff, closed_pos_in;
   logic [3:0]               disc_pos_ff, disc_pos_in;
   logic                     dropped;
   fkd_pkg::kw_step_type     closed_step;
   fkd_pkg::kw_step_type     disc_step;

   always_comb begin
      closed_step = fkd_pkg::kw_step(fkd_pkg::CLOSED_PAT, fkd_pkg::CLOSED_LEN,
                                     {1'b0, closed_pos_ff}, item.rx_byte);
      disc_step   = fkd_pkg::kw_step(fkd_pkg::DISC_PAT, fkd_pkg::DISC_LEN,
                                     disc_pos_ff, item.rx_byte);
   end

   always_comb begin
      done_in       = done_ff;
      armed_in      = armed_ff;
      count_in      = count_ff;
      lost_in       = lost_ff;
      closed_pos_in = closed_pos_ff;
      disc_pos_in   = disc_pos_ff;
      dropped       = 1'b0;
      wr            = '0;
      if (step_en) begin
         case (item.kind)
            fkd_pkg::KIND_BYTE: begin
               if (done_ff) begin
                  dropped = 1'b1;
               end else begin
                  closed_pos_in = closed_step.pos[2:0];
                  disc_pos_in   = disc_step.pos;
                  lost_in       = lost_ff | closed_step.hit | disc_step.hit;
                  if (armed_ff) begin
                     if (item.rx_byte == fkd_pkg::CH_END) begin
                        done_in = 1'b1;
                     end else begin
                        armed_in = 1'b0;
                        count_in = '0;
                     end
                  end else if (item.rx_byte == fkd_pkg::CH_MARK) begin
                     armed_in = 1'b1;
                  end else begin
                     // store the byte; a full buffer restarts the frame at position 0
                     wr.en   = 1'b1;
                     wr.data = item.rx_byte;
                     if (count_ff >= fkd_pkg::CNT_W'(fkd_pkg::BUF_LEN - 1)) begin
                        wr.pos   = '0;
                        count_in = fkd_pkg::CNT_W'(1);
                     end else begin
                        wr.pos   = count_ff;
                        count_in = count_ff + fkd_pkg::CNT_W'(1);
                     end
                  end
               end
            end
            fkd_pkg::KIND_RELEASE: begin
               done_in  = 1'b0;
               armed_in = 1'b0;
               count_in = '0;
            end
            fkd_pkg::KIND_CLEAR_LOST: begin
               lost_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff       <= 1'b0;
         armed_ff      <= 1'b0;
         count_ff      <= '0;
         lost_ff       <= 1'b0;
         closed_pos_ff <= '0;
         disc_pos_ff   <= '0;
      end else begin
         done_ff       <= done_in;
         armed_ff      <= armed_in;
         count_ff      <= count_in;
         lost_ff       <= lost_in;
         closed_pos_ff <= closed_pos_in;
         disc_pos_ff   <= disc_pos_in;
      end
   end

   assign status.done    = done_in;
   assign status.armed   = armed_in;
   assign status.count   = count_in;
   assign status.lost    = lost_in;
   assign status.dropped = dropped;

   a_closed_pos_range: assert property (@(posedge clock) disable iff (reset)
      closed_pos_ff < 3'd6)
      else $error("closed matcher position out of range");

   a_disc_pos_range: assert property (@(posedge clock) disable iff (reset)
      disc_pos_ff < 4'd15)
      else $error("disconnect matcher position out of range");

   a_done_implies_armed: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> armed_ff)
      else $error("frame complete without end marker armed");

   a_complete_freezes: assert property (@(posedge clock) disable iff (reset)
      step_en && done_ff && item.kind == fkd_pkg::KIND_BYTE |=>
         $stable(count_ff) && $stable(closed_pos_ff) && $stable(disc_pos_ff) && $stable(lost_ff))
      else $error("byte changed state while frame complete");

endmodule

@@ hw/rtl/framed_receive_keyword_detect.sv @@
// Top level: input and result registers around the frame core and the two payload banks.
// An accepted beat passes the input register, then the result register, which drives rsp_.
// Throughput: one beat per cycle unless rsp_ stalls; then the input register still refills.
// Payload buffer: two banks (even and odd positions) so a byte and its NUL write together.
// Reset clears the pipeline valids, frame flags, count, matchers and link-lost flag.
// Buffer contents are not cleared; entries read before written return arbitrary data.
module framed_receive_keyword_detect (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] read_index
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] frame_complete, [1] marker_armed,
                                    // [9:2] payload_count, [10] link_lost,
                                    // [18:11] read_data, [19] byte_dropped, [23:20] zero
);

   logic                 s1_valid_ff, s1_valid_in;
   fkd_pkg::item_type    s1_item_ff, s1_item_in;
   logic                 s2_valid_ff, s2_valid_in;
   fkd_pkg::status_type  s2_status_ff, s2_status_in;
   logic                 s2_rd_ok_ff, s2_rd_ok_in;
   logic                 s2_rd_odd_ff, s2_rd_odd_in;

   logic                 s2_free;
   logic                 s1_move;
   logic                 req_accept;
   fkd_pkg::status_type  status;
   fkd_pkg::wr_type      wr;
   logic [fkd_pkg::CNT_W-1:0] nul_pos;
   logic [fkd_pkg::CNT_W-1:0] even_pos;
   logic [fkd_pkg::CNT_W-1:0] odd_pos;
   logic [fkd_pkg::CNT_W-1:0] rd_pos;
   logic                 rd_in_range;
   logic                 rd_en;
   logic [7:0]           even_wdata;
   logic [7:0]           odd_wdata;
   logic [7:0]           even_q;
   logic [7:0]           odd_q;
   logic [7:0]           read_data;

   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in           = 1'b1;
         s1_item_in.kind       = req_tuser;
         s1_item_in.rx_byte    = req_tdata[7:0];
         s1_item_in.read_index = req_tdata[15:8];
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   fkd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_move),
      .item    (s1_item_ff),
      .status  (status),
      .wr      (wr)
   );

   // byte at wr.pos, NUL right after it: the two land in opposite banks
   assign nul_pos    = wr.pos + fkd_pkg::CNT_W'(1);
   assign even_pos   = wr.pos[0] ? nul_pos : wr.pos;
   assign odd_pos    = wr.pos[0] ? wr.pos : nul_pos;
   assign even_wdata = wr.pos[0] ? fkd_pkg::CH_NUL : wr.data;
   assign odd_wdata  = wr.pos[0] ? wr.data : fkd_pkg::CH_NUL;

   assign rd_pos      = fkd_pkg::CNT_W'(s1_item_ff.read_index);
   assign rd_in_range = 32'(s1_item_ff.read_index) < 32'(fkd_pkg::BUF_LEN);
   assign rd_en       = s1_move && (s1_item_ff.kind == fkd_pkg::KIND_READ) && rd_in_range;

   fkd_ram #(
      .WIDTH (8),
      .DEPTH (fkd_pkg::BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (even_pos[fkd_pkg::CNT_W-1:1]),
      .wr_data (even_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_pos[fkd_pkg::CNT_W-1:1]),
      .rd_data (even_q)
   );

   fkd_ram #(
      .WIDTH (8),
      .DEPTH (fkd_pkg::BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (odd_pos[fkd_pkg::CNT_W-1:1]),
      .wr_data (odd_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_pos[fkd_pkg::CNT_W-1:1]),
      .rd_data (odd_q)
   );

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_status_in = s2_status_ff;
      s2_rd_ok_in  = s2_rd_ok_ff;
      s2_rd_odd_in = s2_rd_odd_ff;
      if (s1_move) begin
         s2_valid_in  = 1'b1;
         s2_status_in = status;
         s2_rd_ok_in  = (s1_item_ff.kind == fkd_pkg::KIND_READ) && rd_in_range;
         s2_rd_odd_in = rd_pos[0];
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s2_status_ff <= s2_status_in;
      s2_rd_ok_ff  <= s2_rd_ok_in;
      s2_rd_odd_ff <= s2_rd_odd_in;
   end

   // bank outputs hold while the result stalls: reads fire only on advance
   assign read_data = s2_rd_ok_ff ? (s2_rd_odd_ff ? odd_q : even_q) : 8'd0;

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'd0,
                        s2_status_ff.dropped,
                        read_data,
                        s2_status_ff.lost,
                        8'(s2_status_ff.count),
                        s2_status_ff.armed,
                        s2_status_ff.done};

endmodule

@@ dv/testbench.sv @@
// Framed receive keyword detector testbench: directed and random beats checked by a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES = 200000;
   localparam int TOTAL_BEATS  = 1950;
   localparam int QUIET_AFTER  = 1750;

   typedef struct packed {
      logic       done;
      logic       armed;
      logic [7:0] count;
      logic       lost;
      logic [7:0] read_data;
      logic       dropped;
   } rx_status_type;

   // Frame and keyword predictor plus the queue of expected status beats.
   class rx_frame_scoreboard;
      bit            done, armed, lost;
      int unsigned   count, closed_pos, disc_pos;
      logic [7:0]    payload [fkd_pkg::BUF_LEN];
      bit            written [fkd_pkg::BUF_LEN];
      rx_status_type status_q [$];
      int            mismatches;
      int            results_seen;
      string         closed_kw;
      string         disc_kw;

      function new();
         closed_kw = "CLOSED";
         disc_kw   = "WIFI DISCONNECT";
      endfunction

      // Advance on a hit, restart on a miss; a full match sets link lost.
      function int unsigned step_match(string kw, int unsigned pos, logic [7:0] b);
         if (pos >= kw.len()) pos = 0;
         if (b == kw[pos]) begin
            pos++;
            if (pos >= kw.len()) begin
               lost = 1'b1;
               pos  = 0;
            end
            return pos;
         end
         return (b == kw[0]) ? 1 : 0;
      endfunction

      function void store_payload(logic [7:0] b);
         if (count >= fkd_pkg::BUF_LEN - 1) count = 0;
         payload[count]     = b;
         payload[count + 1] = fkd_pkg::CH_NUL;
         written[count]     = 1'b1;
         written[count + 1] = 1'b1;
         count++;
      endfunction

      function void note_beat(logic [1:0] k, logic [7:0] b, logic [7:0] ix);
         rx_status_type e;
         e = '0;
         case (k)
            fkd_pkg::KIND_BYTE: begin
               if (done) begin
                  e.dropped = 1'b1;
               end else begin
                  closed_pos = step_match(closed_kw, closed_pos, b);
                  disc_pos   = step_match(disc_kw, disc_pos, b);
                  if (armed) begin
                     if (b == fkd_pkg::CH_END) begin
                        done = 1'b1;
                     end else begin
                        armed = 1'b0;
                        count = 0;
                     end
                  end else if (b == fkd_pkg::CH_MARK) begin
                     armed = 1'b1;
                  end else begin
                     store_payload(b);
                  end
               end
            end
            fkd_pkg::KIND_RELEASE: begin
               done  = 1'b0;
               armed = 1'b0;
               count = 0;
            end
            fkd_pkg::KIND_CLEAR_LOST: begin
               lost = 1'b0;
            end
            default: begin
               if (ix < fkd_pkg::BUF_LEN) e.read_data = payload[ix];
            end
         endcase
         e.done  = done;
         e.armed = armed;
         e.count = count[7:0];
         e.lost  = lost;
         status_q.push_back(e);
      endfunction

      task report(string what);
         mismatches++;
         $display("result %0d: %s", results_seen, what);
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s is %h, predicted %h", name, got, want));
      endtask

      task check_result(logic [23:0] d);
         rx_status_type e;
         results_seen++;
         if (status_q.size() == 0) begin
            report("status beat with nothing outstanding");
            return;
         end
         e = status_q.pop_front();
         check_field("frame_complete", 8'(d[0]), 8'(e.done));
         check_field("marker_armed", 8'(d[1]), 8'(e.armed));
         check_field("payload_count", d[9:2], e.count);
         check_field("link_lost", 8'(d[10]), 8'(e.lost));
         check_field("read_data", d[18:11], e.read_data);
         check_field("byte_dropped", 8'(d[19]), 8'(e.dropped));
         check_field("pad", 8'(d[23:20]), 8'd0);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] rx_byte, [15:8] read_index
   logic [1:0]  req_tuser;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [0] frame_complete, [1] marker_armed, [9:2] payload_count,
                             // [10] link_lost, [18:11] read_data, [19] byte_dropped

   rx_frame_scoreboard sb;
   int  beats_sent;
   int  cycles;
   int  stall_left;
   bit  gaps_on;
   bit  stall_on;
   bit  quiet;

   framed_receive_keyword_detect dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Receiver back-pressure in random bursts.
   always @(negedge clock) begin
      if (reset || !stall_on || quiet) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic push_beat(input logic [1:0] k, input logic [7:0] b, input logic [7:0] ix);
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {ix, b};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(k, b, ix);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_beat(fkd_pkg::KIND_BYTE, b, 8'($urandom_range(0, 255)));
   endtask

   task automatic push_cmd(input logic [1:0] k);
      push_beat(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Read only entries that have been written.
   task automatic push_read();
      logic [7:0] ix;
      do ix = 8'($urandom_range(0, 255)); while (!sb.written[ix]);
      push_beat(fkd_pkg::KIND_READ, 8'($urandom_range(0, 255)), ix);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_keyword();
      if ($urandom_range(0, 1)) push_text("CLOSED");
      else push_text("WIFI DISCONNECT");
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.status_q.size() != 0);
   endtask

   function automatic logic [7:0] rand_payload();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == fkd_pkg::CH_MARK);
      return b;
   endfunction

   initial begin
      int         sel;
      int         n;
      bit         drained;
      logic [7:0] b;
      logic [1:0] k;
      string      kw;

      sb         = new();
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = fkd_pkg::KIND_BYTE;
      gaps_on    = 1'b0;
      stall_on   = 1'b0;
      quiet      = 1'b0;
      drained    = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, reads, discard after marker, keyword restart,
      // completion, drop while complete, release.
      push_byte(8'h41);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_beat(fkd_pkg::KIND_READ, 8'h00, 8'd0);
      push_beat(fkd_pkg::KIND_READ, 8'hFF, 8'd3);
      push_byte(fkd_pkg::CH_MARK);
      push_byte("x");
      push_text("CCLOSED");
      push_cmd(fkd_pkg::KIND_CLEAR_LOST);
      push_byte(fkd_pkg::CH_MARK);
      push_byte(fkd_pkg::CH_END);
      push_byte(8'h55);
      push_byte(fkd_pkg::CH_MARK);
      push_beat(fkd_pkg::KIND_READ, 8'h00, 8'd1);
      push_cmd(fkd_pkg::KIND_RELEASE);

      // Overfill one frame so the count wraps and every entry gets written.
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      repeat (300) push_byte(rand_payload());
      push_beat(fkd_pkg::KIND_READ, 8'h00, 8'd255);
      push_beat(fkd_pkg::KIND_READ, 8'h00, 8'd254);

      while (beats_sent < TOTAL_BEATS) begin
         if (beats_sent >= QUIET_AFTER) quiet = 1'b1;
         gaps_on  = $urandom_range(0, 3) != 0;
         stall_on = $urandom_range(0, 3) != 0;
         if (!drained && beats_sent > 1000) begin
            drained = 1'b1;
            wait_drained();
         end
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            if (sb.done || sb.armed) push_cmd(fkd_pkg::KIND_RELEASE);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
            repeat (n) push_byte(rand_payload());
            if ($urandom_range(0, 4) == 0) push_keyword();
            push_byte(fkd_pkg::CH_MARK);
            push_byte(fkd_pkg::CH_END);
            repeat ($urandom_range(0, 3)) push_read();
            if ($urandom_range(0, 2) == 0) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) push_cmd(fkd_pkg::KIND_RELEASE);
         end else if (sel < 60) begin
            if (sb.done) push_cmd(fkd_pkg::KIND_RELEASE);
            if ($urandom_range(0, 1)) kw = "CLOSED";
            else kw = "WIFI DISCONNECT";
            // Corrupt one character now and then.
            if ($urandom_range(0, 2) == 0)
               kw[$urandom_range(0, kw.len() - 1)] = 8'($urandom_range(1, 255));
            push_text(kw);
            if ($urandom_range(0, 1)) push_cmd(fkd_pkg::KIND_CLEAR_LOST);
         end else if (sel < 70) begin
            if (sb.done) push_cmd(fkd_pkg::KIND_RELEASE);
            repeat ($urandom_range(0, 6)) push_byte(rand_payload());
            push_byte(fkd_pkg::CH_MARK);
            do b = 8'($urandom_range(0, 255)); while (b == fkd_pkg::CH_END);
            push_byte(b);
         end else if (sel < 92) begin
            repeat ($urandom_range(1, 12)) begin
               k = 2'($urandom_range(0, 3));
               if (k == fkd_pkg::KIND_READ) push_read();
               else push_beat(k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 4)) push_read();
         end
      end

      quiet = 1'b1;
      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/fkd_pkg.sv
hw/rtl/fkd_ram.sv
hw/rtl/fkd_core.sv
hw/rtl/framed_receive_keyword_detect.sv
dv/testbench.sv
